@@ hw/rtl/ost_pkg.sv @@
package ost_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT_AT     = 3'd0,
        FN_INSERT_SORTED = 3'd1,
        FN_ERASE_AT      = 3'd2,
        FN_REMOVE_ALL    = 3'd3,
        FN_GET           = 3'd4,
        FN_SET           = 3'd5,
        FN_FIND          = 3'd6,
        FN_NOP           = 3'd7
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN,
        OP_MARK_VAL,
        OP_MARK_POS
    } t_cell_op;

    typedef struct packed {
        logic dead;
        logic hit;
        logic ge;
    } t_cell_flags;

endpackage

@@ hw/rtl/ost_if.sv @@
interface ost_req_if import ost_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output func, output position, output item_value,
                    input ready);
    modport sink (input valid, input func, input position, input item_value,
                  output ready);
endinterface

interface ost_rsp_if import ost_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         result_index;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       removed_count;
    logic [COUNT_W-1:0]       entry_count;

    modport source (output valid, output status, output result_index, output read_value,
                    output removed_count, output entry_count, input ready);
    modport sink (input valid, input status, input result_index, input read_value,
                  input removed_count, input entry_count, output ready);
endinterface

@@ hw/rtl/ordered_sequence_table.sv @@
// Bounded ordered list of signed words kept in a row of cells, one entry per cell.
// Requests arrive on i_req (func, position, item_value) and each one gives exactly
// one item on o_rsp (status, result_index, read_value, removed_count, entry_count).
// Every operation drives all cells at once: shifts, writes and compares act on the
// whole row together, and a priority encoder picks the first hit.
// Each request passes from S_IDLE through S_MARK to S_OUT, which loads o_rsp;
// insert_sorted and find add S_EXEC (except insert_sorted into a full table), and
// erase_at and remove_all add S_COMPACT (except erase_at at a bad position).
// Removal compacts the row one removed entry per cycle, which sets the length of
// remove_all. One request is in work at a time; i_req.ready rises at the edge that
// loads the result into the output register.
// If the receiver holds o_rsp.ready low, the result stays in the output register
// and a finished request waits for it before loading its own result.
// Reset empties the list; the cell contents are not cleared and are never read
// before they are written.
module ordered_sequence_table import ost_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ost_req_if.sink   i_req,
    ost_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {S_IDLE, S_MARK, S_EXEC, S_COMPACT, S_OUT} t_state;

    t_state                r_state;
    t_func                 r_func;
    logic [POS_W-1:0]      r_pos;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CAPACITY-1:0]   r_hit;
    logic [CAPACITY-1:0]   r_ge;
    logic [CW-1:0]         r_removed;
    t_status               r_status;
    logic [CW-1:0]         r_rindex;
    logic [VALUE_BITS-1:0] r_rval;

    logic                  r_o_valid;
    t_status               r_o_status;
    logic [POS_W-1:0]      r_o_rindex;
    logic [DATA_W-1:0]     r_o_rval;
    logic [COUNT_W-1:0]    r_o_removed;
    logic [COUNT_W-1:0]    r_o_count;

    t_status               n_status;
    logic [CW-1:0]         n_rindex;
    logic [VALUE_BITS-1:0] n_rval;
    t_state                w_mark_next;

    logic [VALUE_BITS-1:0] w_value [CAPACITY];
    t_cell_flags           w_flags [CAPACITY];
    logic [CAPACITY-1:0]   w_dead_vec;
    logic [CAPACITY-1:0]   w_hit_vec;
    logic [CAPACITY-1:0]   w_ge_vec;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_cnt;
    logic                  w_full;
    logic                  w_any_dead;
    logic                  w_any_hit;
    logic                  w_any_ge;
    logic [CW-1:0]         w_first_dead;
    logic [CW-1:0]         w_first_hit;
    logic [CW-1:0]         w_first_ge;
    logic [VALUE_BITS-1:0] w_rd;
    t_cell_op              w_op;
    logic [CW-1:0]         w_k;
    logic                  w_out_free;

    assign w_pos      = PW'(r_pos);
    assign w_cnt      = PW'(r_count);
    assign w_full     = r_count >= CW'(CAPACITY);
    assign w_out_free = !r_o_valid || o_rsp.ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_BITS-1:0] w_left;
            logic [VALUE_BITS-1:0] w_right;
            logic                  w_right_dead;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_value[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right      = '0;
                assign w_right_dead = 1'b0;
            end else begin : g_mid_r
                assign w_right      = w_value[g+1];
                assign w_right_dead = w_flags[g+1].dead;
            end
            ost_cell #(
                .INDEX      (g),
                .CW         (CW),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (w_op),
                .i_k           (w_k),
                .i_count       (r_count),
                .i_value       (r_val),
                .i_left_value  (w_left),
                .i_right_value (w_right),
                .i_right_dead  (w_right_dead),
                .o_value       (w_value[g]),
                .o_flags       (w_flags[g])
            );
            assign w_dead_vec[g] = w_flags[g].dead;
            assign w_hit_vec[g]  = w_flags[g].hit;
            assign w_ge_vec[g]   = w_flags[g].ge;
        end
    endgenerate

    always_comb begin
        w_first_dead = '0;
        w_first_hit  = '0;
        w_first_ge   = r_count;
        w_rd         = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_dead_vec[i]) begin
                w_first_dead = CW'(i);
            end
            if (r_hit[i]) begin
                w_first_hit = CW'(i);
            end
            if (r_ge[i]) begin
                w_first_ge = CW'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i) == w_pos) begin
                w_rd = w_rd | w_value[i];
            end
        end
    end

    assign w_any_dead = |w_dead_vec;
    assign w_any_hit  = |r_hit;
    assign w_any_ge   = |r_ge;

    always_comb begin
        w_op = OP_NONE;
        w_k  = CW'(r_pos);
        case (r_state)
            S_MARK: begin
                case (r_func)
                    FN_INSERT_AT: begin
                        if (w_pos <= w_cnt && !w_full) begin
                            w_op = OP_SHIFT_UP;
                        end
                    end
                    FN_ERASE_AT: begin
                        if (w_pos < w_cnt) begin
                            w_op = OP_MARK_POS;
                        end
                    end
                    FN_REMOVE_ALL: w_op = OP_MARK_VAL;
                    FN_SET: begin
                        if (w_pos < w_cnt) begin
                            w_op = OP_WRITE;
                        end
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                if (r_func == FN_INSERT_SORTED) begin
                    w_op = OP_SHIFT_UP;
                    w_k  = w_first_ge;
                end
            end
            S_COMPACT: begin
                if (w_any_dead) begin
                    w_op = OP_SHIFT_DOWN;
                    w_k  = w_first_dead;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_status    = ST_OK;
        n_rindex    = '0;
        n_rval      = '0;
        w_mark_next = S_OUT;
        case (r_func)
            FN_INSERT_AT: begin
                if (w_pos > w_cnt) begin
                    n_status = ST_BAD_POS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_rindex = CW'(r_pos);
                end
            end
            FN_INSERT_SORTED: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_mark_next = S_EXEC;
                end
            end
            FN_ERASE_AT: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BAD_POS;
                end else begin
                    w_mark_next = S_COMPACT;
                end
            end
            FN_REMOVE_ALL: w_mark_next = S_COMPACT;
            FN_GET: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_rval = w_rd;
                end
            end
            FN_SET: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BAD_POS;
                end
            end
            FN_FIND: w_mark_next = S_EXEC;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_rsp.ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func    <= t_func'(i_req.func);
                        r_pos     <= i_req.position;
                        r_val     <= VALUE_BITS'(i_req.item_value);
                        r_removed <= '0;
                        r_state   <= S_MARK;
                    end
                end
                S_MARK: begin
                    r_hit    <= w_hit_vec;
                    r_ge     <= w_ge_vec;
                    r_status <= n_status;
                    r_rindex <= n_rindex;
                    r_rval   <= n_rval;
                    r_state  <= w_mark_next;
                    if (r_func == FN_INSERT_AT && n_status == ST_OK) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_EXEC: begin
                    if (r_func == FN_INSERT_SORTED) begin
                        r_rindex <= w_any_ge ? w_first_ge : r_count;
                        r_count  <= r_count + 1'b1;
                    end else if (w_any_hit) begin
                        r_rindex <= w_first_hit;
                    end else begin
                        r_status <= ST_NOT_FOUND;
                    end
                    r_state <= S_OUT;
                end
                S_COMPACT: begin
                    if (w_any_dead) begin
                        r_count   <= r_count - 1'b1;
                        r_removed <= r_removed + 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_rindex  <= POS_W'(r_rindex);
                        r_o_rval    <= DATA_W'($signed(r_rval));
                        r_o_removed <= (r_func == FN_REMOVE_ALL) ? COUNT_W'(r_removed) : '0;
                        r_o_count   <= COUNT_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.result_index  = r_o_rindex;
    assign o_rsp.read_value    = r_o_rval;
    assign o_rsp.removed_count = r_o_removed;
    assign o_rsp.entry_count   = r_o_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == CW'($past(r_count) + 1'b1))
        || (r_count == CW'($past(r_count) - 1'b1)))
        else $error("Entry count moved by more than one in a cycle.");

    a_compact_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !w_any_dead)
        else $error("Result issued while removed entries remain in the row.");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT))
        else $error("Result loaded outside the output state.");

    a_dead_only_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EXEC) |-> !w_any_dead)
        else $error("Removal mark left outside compaction.");
`endif

endmodule

@@ hw/rtl/ost_cell.sv @@
module ost_cell import ost_pkg::*; #(
    parameter int INDEX      = 0,
    parameter int CW         = 7,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_op              i_op,
    input  logic [CW-1:0]         i_k,
    input  logic [CW-1:0]         i_count,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_right_dead,
    output logic [VALUE_BITS-1:0] o_value,
    output t_cell_flags           o_flags
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  r_dead;
    logic                  n_dead;
    logic                  w_valid;
    logic                  w_at_k;
    logic                  w_above_k;
    logic                  w_hit;
    logic                  w_ge;

    assign w_valid   = MY_INDEX < i_count;
    assign w_at_k    = MY_INDEX == i_k;
    assign w_above_k = MY_INDEX > i_k;
    assign w_hit     = w_valid && (r_value == i_value);
    assign w_ge      = w_valid && !($signed(r_value) < $signed(i_value));

    always_comb begin
        n_value = r_value;
        n_dead  = r_dead;
        case (i_op)
            OP_WRITE: begin
                if (w_at_k) begin
                    n_value = i_value;
                end
            end
            OP_SHIFT_UP: begin
                if (w_above_k) begin
                    n_value = i_left_value;
                end else if (w_at_k) begin
                    n_value = i_value;
                end
            end
            OP_SHIFT_DOWN: begin
                if (w_at_k || w_above_k) begin
                    n_value = i_right_value;
                    n_dead  = i_right_dead;
                end
            end
            OP_MARK_VAL: n_dead = w_hit;
            OP_MARK_POS: n_dead = w_valid && w_at_k;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else begin
            r_dead <= n_dead;
        end
    end

    assign o_value = r_value;
    assign o_flags = '{dead: r_dead, hit: w_hit, ge: w_ge};

endmodule

@@ sim/ordered_sequence_table_test.sv @@
`timescale 1ns / 1ps

module ordered_sequence_table_test;
    import ost_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES       = 18;
    localparam int PHASE_ITEMS  = 100;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;

    typedef enum int {
        PROFILE_FILL,
        PROFILE_CHURN,
        PROFILE_DRAIN
    } t_profile;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         result_index;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       removed_count;
        logic [COUNT_W-1:0]       entry_count;
    } t_result;

    typedef struct {
        t_func                    func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
        bit                       typed_in;
        t_result                  want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ost_req_if req_bus ();
    ost_rsp_if rsp_bus ();

    ordered_sequence_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int      list_count;
    t_result pending_results [$];
    t_row    script [$];
    int      mismatch_count;
    int      idle_cycles;
    int      send_calm;
    bit      hold_request;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic t_result apply_request(t_func f, logic [POS_W-1:0] p,
                                              logic signed [DATA_W-1:0] v);
        t_result r;
        int      slot;
        int      keep;
        bit      hit;
        r = '0;
        r.status = ST_OK;
        case (f)
            FN_INSERT_AT, FN_INSERT_SORTED: begin
                slot = p;
                if (f == FN_INSERT_SORTED) begin
                    slot = list_count;
                    hit = 1'b0;
                    for (int i = 0; i < list_count; i++) begin
                        if (!hit && list_mem[i] >= v) begin
                            slot = i;
                            hit = 1'b1;
                        end
                    end
                end
                if (f == FN_INSERT_AT && int'(p) > list_count) begin
                    r.status = ST_BAD_POS;
                end else if (list_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_count; i > slot; i--) list_mem[i] = list_mem[i-1];
                    list_mem[slot] = v;
                    list_count++;
                    r.result_index = POS_W'(slot);
                end
            end
            FN_ERASE_AT: begin
                if (int'(p) >= list_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int i = p; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            end
            FN_REMOVE_ALL: begin
                keep = 0;
                for (int i = 0; i < list_count; i++) begin
                    if (list_mem[i] != v) begin
                        list_mem[keep] = list_mem[i];
                        keep++;
                    end
                end
                r.removed_count = COUNT_W'(list_count - keep);
                list_count = keep;
            end
            FN_GET: begin
                if (int'(p) >= list_count) r.status = ST_BAD_POS;
                else r.read_value = list_mem[p];
            end
            FN_SET: begin
                if (int'(p) >= list_count) r.status = ST_BAD_POS;
                else list_mem[p] = v;
            end
            FN_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < list_count; i++) begin
                    if (r.status == ST_NOT_FOUND && list_mem[i] == v) begin
                        r.status = ST_OK;
                        r.result_index = POS_W'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = COUNT_W'(list_count);
        return r;
    endfunction

    task automatic add_row(t_func f, int p, logic signed [DATA_W-1:0] v, bit typed_in,
                           t_status st, int idx, int cnt);
        t_row row;
        row.func = f;
        row.position = POS_W'(p);
        row.item_value = v;
        row.typed_in = typed_in;
        row.want = '0;
        row.want.status = st;
        row.want.result_index = POS_W'(idx);
        row.want.entry_count = COUNT_W'(cnt);
        script.push_back(row);
    endtask

    task automatic send_request(t_row row);
        int      gap;
        t_result predicted;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.func <= row.func;
        req_bus.position <= row.position;
        req_bus.item_value <= row.item_value;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predicted = apply_request(row.func, row.position, row.item_value);
        pending_results.push_back(row.typed_in ? row.want : predicted);
    endtask

    task automatic compare_result(t_result want, t_result got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
            mismatch_count++;
        end
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            mismatch_count++;
        end
        if (got.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, got %0d", want.removed_count,
                   got.removed_count);
            mismatch_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            mismatch_count++;
        end
    endtask

    initial begin
        int      gap;
        int      recv_calm;
        t_result got;
        rsp_bus.ready <= 1'b0;
        recv_calm = 0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(recv_calm);
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_bus.valid) @(posedge i_clk);
            got.status = rsp_bus.status;
            got.result_index = rsp_bus.result_index;
            got.read_value = rsp_bus.read_value;
            got.removed_count = rsp_bus.removed_count;
            got.entry_count = rsp_bus.entry_count;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d, entry_count %0d",
                       got.status, got.entry_count);
                mismatch_count++;
            end else begin
                compare_result(pending_results.pop_front(), got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row     row;
        t_profile profile;
        int       pick;
        i_rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.func <= FN_NOP;
        req_bus.position <= '0;
        req_bus.item_value <= '0;
        list_count = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_calm = 0;
        hold_request = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(FN_GET,             0,  0,        1, ST_BAD_POS,   0, 0);
        add_row(FN_ERASE_AT,        0,  0,        1, ST_BAD_POS,   0, 0);
        add_row(FN_SET,           127, -1,        1, ST_BAD_POS,   0, 0);
        add_row(FN_FIND,            0,  5,        1, ST_NOT_FOUND, 0, 0);
        add_row(FN_REMOVE_ALL,      0,  5,        1, ST_OK,        0, 0);
        add_row(FN_INSERT_AT,       1,  7,        1, ST_BAD_POS,   0, 0);
        add_row(FN_NOP,             0,  9,        1, ST_OK,        0, 0);
        add_row(FN_INSERT_SORTED,   0,  100,      1, ST_OK,        0, 1);
        add_row(FN_INSERT_AT,       0,  WORD_MAX, 1, ST_OK,        0, 2);
        add_row(FN_INSERT_AT,       2,  WORD_MIN, 1, ST_OK,        2, 3);
        add_row(FN_INSERT_AT,       4,  1,        1, ST_BAD_POS,   0, 3);
        add_row(FN_INSERT_SORTED,   0, -5,        0, ST_OK,        0, 0);
        add_row(FN_GET,             0,  0,        0, ST_OK,        0, 0);
        add_row(FN_GET,             3,  0,        0, ST_OK,        0, 0);
        add_row(FN_SET,             1, -1,        0, ST_OK,        0, 0);
        add_row(FN_FIND,            0,  100,      0, ST_OK,        0, 0);
        add_row(FN_INSERT_SORTED,   0,  100,      0, ST_OK,        0, 0);
        add_row(FN_INSERT_AT,       5,  100,      0, ST_OK,        0, 0);
        add_row(FN_REMOVE_ALL,      0,  100,      0, ST_OK,        0, 0);
        add_row(FN_FIND,            0,  100,      0, ST_OK,        0, 0);
        add_row(FN_GET,            64,  0,        0, ST_OK,        0, 0);
        add_row(FN_ERASE_AT,        0,  0,        0, ST_OK,        0, 0);
        add_row(FN_ERASE_AT,        3,  0,        0, ST_OK,        0, 0);
        add_row(FN_NOP,           127, -1,        0, ST_OK,        0, 0);
        foreach (script[i]) send_request(script[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) profile = PROFILE_FILL;
            else if (phase == 1) profile = PROFILE_DRAIN;
            else profile = t_profile'($urandom_range(0, 2));
            if (phase == 6) hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                case (profile)
                    PROFILE_FILL: begin
                        if (pick < 40) row.func = FN_INSERT_AT;
                        else if (pick < 80) row.func = FN_INSERT_SORTED;
                        else row.func = t_func'($urandom_range(2, 7));
                    end
                    PROFILE_DRAIN: begin
                        if (pick < 40) row.func = FN_ERASE_AT;
                        else if (pick < 60) row.func = FN_REMOVE_ALL;
                        else row.func = t_func'($urandom_range(0, 7));
                    end
                    default: begin
                        row.func = t_func'($urandom_range(0, 7));
                    end
                endcase

                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    row.item_value = $urandom_range(0, 6) - 3;
                end else if (pick < 6 && list_count > 0) begin
                    row.item_value = list_mem[$urandom_range(0, list_count - 1)];
                end else if (pick < 7) begin
                    case ($urandom_range(0, 3))
                        0: row.item_value = WORD_MAX;
                        1: row.item_value = WORD_MIN;
                        2: row.item_value = 0;
                        default: row.item_value = -1;
                    endcase
                end else begin
                    row.item_value = $urandom;
                end

                pick = $urandom_range(0, 9);
                if (pick == 0) row.position = POS_W'($urandom_range(0, 127));
                else if (pick == 1) row.position = POS_W'(list_count);
                else row.position = POS_W'($urandom_range(0, list_count > 0 ? list_count - 1 : 0));

                row.typed_in = 1'b0;
                row.want = '0;
                send_request(row);
            end
            if (phase % 4 == 3) begin
                req_bus.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
